### rtl/tvfp_pkg.sv
// tvfp_pkg: shared types and constants for the tag/value field parser.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package tvfp_pkg;

   localparam int KEY_W    = 20;
   localparam int OFFSET_W = 12;
   localparam int SLOT_W   = 2;
   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int MAX_SLOTS = 4;

   localparam logic [KEY_W-1:0]    KEY_MAX    = 20'd999999;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = 12'd4095;

   localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_SOH  = 8'h01;
   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

   localparam logic [KIND_W-1:0] KIND_MATCH     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START_ERR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BAD_KEY   = 2'd2;

   // reset values of the tag slot registers
   localparam logic [KEY_W-1:0] TAG_RESET [MAX_SLOTS] = '{20'd1, 20'd2, 20'd3, 20'd0};

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_KEY   = 2'd1,
      PH_VALUE = 2'd2,
      PH_ERROR = 2'd3
   } phase_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } match_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SLOT_W-1:0]   slot;
      logic [OFFSET_W-1:0] value_offset;
      logic [KEY_W-1:0]    key_seen;
   } result_type;

endpackage

### rtl/tag_value_field_parser.sv
// tag_value_field_parser: byte-serial key=value field parser, top level.
// A req beat that yields a result passes the input register, then the result
// register, to its rsp beat. Throughput: one byte per cycle unless rsp_tready stalls.
// Reset (synchronous, active high) empties both registers, clears the parse
// state and loads the tag slots with 1, 2, 3, 0.
// Depends on tvfp_pkg, tvfp_tag_table and tvfp_rsp_reg.
`timescale 1ns / 1ps

module tag_value_field_parser #(
   parameter int NUM_TAGS      = 4,
   parameter int MAX_MSG_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // msg_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] slot, [13:2] value_offset, [33:14] key_seen
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   localparam int KW = tvfp_pkg::KEY_W;
   localparam int OW = tvfp_pkg::OFFSET_W;
   localparam logic [OW-1:0] POS_CAP =
      ((MAX_MSG_BYTES - 1) < 4095) ? OW'(MAX_MSG_BYTES - 1) : tvfp_pkg::OFFSET_MAX;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // parse state
   tvfp_pkg::phase_type phase_ff, phase_in;
   logic [KW-1:0]       key_ff, key_in;
   logic                big_ff, big_in;
   logic [OW-1:0]       pos_ff, pos_in;

   logic                 can_load;
   logic                 advance;
   logic                 emit;
   tvfp_pkg::result_type result;
   tvfp_pkg::result_type rsp_data;
   tvfp_pkg::match_type  match;

   logic          is_digit;
   logic [3:0]    digit;
   logic [KW+3:0] key_prod;
   logic [KW-1:0] key_add;
   logic          big_add;
   logic [KW-1:0] key_base;
   logic          big_base;

   assign advance    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   tvfp_tag_table #(
      .NUM_TAGS (NUM_TAGS)
   ) u_tag_table (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key       (key_ff),
      .match     (match)
   );

   assign is_digit = (in_byte_ff >= tvfp_pkg::CH_ZERO) && (in_byte_ff <= tvfp_pkg::CH_NINE);
   assign digit    = in_byte_ff[3:0];

   // a new key starts from zero at the start of a field
   assign key_base = (phase_ff == tvfp_pkg::PH_START) ? '0 : key_ff;
   assign big_base = (phase_ff == tvfp_pkg::PH_START) ? 1'b0 : big_ff;

   // key * 10 + digit, clamped at the largest legal key
   always_comb begin
      key_prod = {key_base, 3'b000} + {2'b00, key_base, 1'b0} + (KW+4)'(digit);
      key_add  = key_base;
      big_add  = big_base;
      if (!big_base) begin
         if (key_prod > (KW+4)'(tvfp_pkg::KEY_MAX)) begin
            key_add = tvfp_pkg::KEY_MAX;
            big_add = 1'b1;
         end else begin
            key_add = key_prod[KW-1:0];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      key_in   = key_ff;
      big_in   = big_ff;
      emit     = 1'b0;
      result   = '0;
      case (phase_ff)
         tvfp_pkg::PH_START: begin
            if ((in_byte_ff == tvfp_pkg::CH_EQ) || (in_byte_ff == tvfp_pkg::CH_SOH)) begin
               emit        = 1'b1;
               result.kind = tvfp_pkg::KIND_START_ERR;
               phase_in    = tvfp_pkg::PH_ERROR;
            end else if (is_digit) begin
               key_in   = key_add;
               big_in   = big_add;
               phase_in = tvfp_pkg::PH_KEY;
            end else begin
               emit        = 1'b1;
               result.kind = tvfp_pkg::KIND_BAD_KEY;
               phase_in    = tvfp_pkg::PH_ERROR;
            end
         end
         tvfp_pkg::PH_KEY: begin
            if (is_digit) begin
               key_in = key_add;
               big_in = big_add;
            end else if (in_byte_ff == tvfp_pkg::CH_EQ) begin
               if (big_ff || (key_ff == '0)) begin
                  emit            = 1'b1;
                  result.kind     = tvfp_pkg::KIND_BAD_KEY;
                  result.key_seen = key_ff;
                  phase_in        = tvfp_pkg::PH_ERROR;
               end else begin
                  emit                = match.hit;
                  result.kind         = tvfp_pkg::KIND_MATCH;
                  result.slot         = match.slot;
                  result.value_offset = (pos_ff < POS_CAP) ? pos_ff + 1'b1 : POS_CAP;
                  result.key_seen     = key_ff;
                  phase_in            = tvfp_pkg::PH_VALUE;
               end
            end else begin
               emit            = 1'b1;
               result.kind     = tvfp_pkg::KIND_BAD_KEY;
               result.key_seen = key_ff;
               phase_in        = tvfp_pkg::PH_ERROR;
            end
         end
         tvfp_pkg::PH_VALUE: begin
            if (in_byte_ff == tvfp_pkg::CH_SOH) begin
               phase_in = tvfp_pkg::PH_START;
               key_in   = '0;
               big_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // message ends inside a key
      if (in_last_ff && (phase_in == tvfp_pkg::PH_KEY) && !emit) begin
         emit   = 1'b1;
         result = '0;
         result.kind     = tvfp_pkg::KIND_BAD_KEY;
         result.key_seen = key_in;
      end

      if (in_last_ff) begin
         phase_in = tvfp_pkg::PH_START;
         key_in   = '0;
         big_in   = 1'b0;
         pos_in   = '0;
      end else begin
         pos_in = (pos_ff < POS_CAP) ? pos_ff + 1'b1 : POS_CAP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tvfp_pkg::PH_START;
         key_ff   <= '0;
         big_ff   <= 1'b0;
         pos_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         key_ff   <= key_in;
         big_ff   <= big_in;
         pos_ff   <= pos_in;
      end
   end

   tvfp_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (emit),
      .load_data  (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tuser = rsp_data.kind;
   assign rsp_tdata = {6'b000000, rsp_data.key_seen, rsp_data.value_offset, rsp_data.slot};

endmodule

### rtl/tvfp_tag_table.sv
// tvfp_tag_table: tag slot registers written from the CSR port, plus the
// priority lookup of a key. Depends on tvfp_pkg.
`timescale 1ns / 1ps

module tvfp_tag_table #(
   parameter int NUM_TAGS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [tvfp_pkg::KEY_W-1:0] csr_wdata,
   input  logic [tvfp_pkg::KEY_W-1:0] key,
   output tvfp_pkg::match_type        match
);

   logic [tvfp_pkg::KEY_W-1:0] tag_ff [NUM_TAGS];

   for (genvar i = 0; i < NUM_TAGS; i++) begin : g_tag
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= tvfp_pkg::TAG_RESET[i];
         end else if (csr_we && (csr_index == 2'(i))) begin
            tag_ff[i] <= csr_wdata;
         end
      end
   end

   // scan downward so the lowest matching slot wins
   always_comb begin
      match = '0;
      for (int i = NUM_TAGS - 1; i >= 0; i--) begin
         if ((tag_ff[i] != '0) && (tag_ff[i] == key)) begin
            match.hit  = 1'b1;
            match.slot = tvfp_pkg::SLOT_W'(i);
         end
      end
   end

endmodule

### rtl/tvfp_rsp_reg.sv
// tvfp_rsp_reg: result register for the response stream; takes a new beat
// whenever it is empty or its beat is being taken. Depends on tvfp_pkg.
`timescale 1ns / 1ps

module tvfp_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,       // step the register this cycle
   input  logic                 load_valid, // the stepped item carries a result
   input  tvfp_pkg::result_type load_data,
   output logic                 can_load,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output tvfp_pkg::result_type rsp_data
);

   logic                 valid_ff;
   logic                 valid_in;
   tvfp_pkg::result_type data_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = load_valid;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule
